// File: rtl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg: shared types, microcode and saturation helpers
// Control word layout, sequencer/datapath handshake structs and the
// microprogram for the difference-bound closure block.
// ----------------------------------------------------------------------------
package dbc_pkg;

    localparam int STORE_W = 26;   // working distance width
    localparam int OUT_W   = 18;   // emitted distance width
    localparam int IDX_W   = 2;    // emitted row/column index width
    localparam int PC_W    = 4;    // microprogram counter width

    // Program labels
    localparam logic [PC_W-1:0] PC_LOAD  = 4'd0;
    localparam logic [PC_W-1:0] PC_RELAX = 4'd1;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd4;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd9;

    typedef struct packed {
        logic                      inf;
        logic signed [STORE_W-1:0] val;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_RD_AB,
        OP_RD_I,
        OP_RELAX,
        OP_CHECK,
        OP_EMIT_LD,
        OP_FAIL
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_MORE_CELLS,
        COND_MORE_TRIPLES,
        COND_MORE_OK,
        COND_OK
    } cond_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CELL,
        CNT_TRIPLE,
        CNT_CLEAR
    } cnt_t;

    typedef struct packed {
        op_t             op;
        logic            wait_in;
        logic            wait_out;
        cond_t           cond;
        cnt_t            cnt;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic go;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic out_free;
        logic improve;
    } status_t;

    // Microprogram ROM
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            unique case (pc)
                4'd0:    w = '{op: OP_LOAD, wait_in: 1'b1, wait_out: 1'b0,
                               cond: COND_MORE_CELLS, cnt: CNT_CELL, target: PC_LOAD};
                4'd1:    w = '{op: OP_RD_AB, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_NONE, cnt: CNT_HOLD, target: PC_LOAD};
                4'd2:    w = '{op: OP_RD_I, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_NONE, cnt: CNT_HOLD, target: PC_LOAD};
                4'd3:    w = '{op: OP_RELAX, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_MORE_TRIPLES, cnt: CNT_TRIPLE, target: PC_RELAX};
                4'd4:    w = '{op: OP_RD_AB, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_NONE, cnt: CNT_HOLD, target: PC_LOAD};
                4'd5:    w = '{op: OP_RD_I, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_NONE, cnt: CNT_HOLD, target: PC_LOAD};
                4'd6:    w = '{op: OP_CHECK, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_MORE_OK, cnt: CNT_TRIPLE, target: PC_CHECK};
                4'd7:    w = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_OK, cnt: CNT_HOLD, target: PC_EMIT};
                4'd8:    w = '{op: OP_FAIL, wait_in: 1'b0, wait_out: 1'b1,
                               cond: COND_ALWAYS, cnt: CNT_CLEAR, target: PC_LOAD};
                4'd9:    w = '{op: OP_RD_I, wait_in: 1'b0, wait_out: 1'b1,
                               cond: COND_NONE, cnt: CNT_HOLD, target: PC_LOAD};
                4'd10:   w = '{op: OP_EMIT_LD, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_MORE_CELLS, cnt: CNT_CELL, target: PC_EMIT};
                default: w = '{op: OP_NOP, wait_in: 1'b0, wait_out: 1'b0,
                               cond: COND_ALWAYS, cnt: CNT_CLEAR, target: PC_LOAD};
            endcase
            return w;
        end
    endfunction

    // Saturate a one-bit-grown sum back to the store width
    function automatic logic signed [STORE_W-1:0] sat_store(
        input logic signed [STORE_W:0] s
    );
        logic signed [STORE_W-1:0] res;
        begin
            if (s[STORE_W] != s[STORE_W-1])
                res = s[STORE_W] ? {1'b1, {(STORE_W-1){1'b0}}}
                                 : {1'b0, {(STORE_W-1){1'b1}}};
            else
                res = s[STORE_W-1:0];
            return res;
        end
    endfunction

    // Saturate a stored distance to the emitted width
    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [STORE_W-1:0] v
    );
        logic signed [OUT_W-1:0] res;
        begin
            if ((&v[STORE_W-1:OUT_W-1]) || !(|v[STORE_W-1:OUT_W-1]))
                res = v[OUT_W-1:0];
            else
                res = v[STORE_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                   : {1'b0, {(OUT_W-1){1'b1}}};
            return res;
        end
    endfunction

endpackage

// File: rtl/dbc_sequencer.sv
// ----------------------------------------------------------------------------
// dbc_sequencer: microprogram counter and loop counters
// Fetches one control word per step, holds on stream waits, evaluates
// conditional jumps and advances the k/r/c loop counters.
// ----------------------------------------------------------------------------
module dbc_sequencer #(
    parameter int NODES = 4,
    localparam int NODE_W = $clog2(NODES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dbc_pkg::status_t    status,
    output dbc_pkg::ctrl_t      ctrl,
    output logic [NODE_W-1:0]   k_idx,
    output logic [NODE_W-1:0]   r_idx,
    output logic [NODE_W-1:0]   c_idx
);

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    logic [dbc_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [NODE_W-1:0]        k_reg, k_next;
    logic [NODE_W-1:0]        r_reg, r_next;
    logic [NODE_W-1:0]        c_reg, c_next;
    logic                     bad_reg, bad_next;

    dbc_pkg::uword_t word;
    logic            go;
    logic            cell_last;
    logic            triple_last;
    logic            jump;

    assign word        = dbc_pkg::ucode(pc_reg);
    assign go          = (!word.wait_in || status.accept) && (!word.wait_out || status.out_free);
    assign cell_last   = (r_reg == LAST_NODE) && (c_reg == LAST_NODE);
    assign triple_last = cell_last && (k_reg == LAST_NODE);

    always_comb
    begin
        unique case (word.cond)
            dbc_pkg::COND_NONE:         jump = 1'b0;
            dbc_pkg::COND_ALWAYS:       jump = 1'b1;
            dbc_pkg::COND_MORE_CELLS:   jump = !cell_last;
            dbc_pkg::COND_MORE_TRIPLES: jump = !triple_last;
            dbc_pkg::COND_MORE_OK:      jump = !status.improve && !triple_last;
            dbc_pkg::COND_OK:           jump = !bad_reg;
            default:                    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
            pc_next = jump ? word.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        k_next = k_reg;
        r_next = r_reg;
        c_next = c_reg;
        if (go)
        begin
            unique case (word.cnt) inside
                dbc_pkg::CNT_HOLD: ;
                dbc_pkg::CNT_CELL, dbc_pkg::CNT_TRIPLE:
                begin
                    c_next = (c_reg == LAST_NODE) ? '0 : c_reg + 1'b1;
                    if (c_reg == LAST_NODE)
                        r_next = (r_reg == LAST_NODE) ? '0 : r_reg + 1'b1;
                    if (word.cnt == dbc_pkg::CNT_TRIPLE && cell_last)
                        k_next = (k_reg == LAST_NODE) ? '0 : k_reg + 1'b1;
                end
                dbc_pkg::CNT_CLEAR:
                begin
                    k_next = '0;
                    r_next = '0;
                    c_next = '0;
                end
                default: ;
            endcase
        end
    end

    // Latch the outcome of each check step for the branch after the sweep
    assign bad_next = (word.op == dbc_pkg::OP_CHECK) ? status.improve : bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= dbc_pkg::PC_LOAD;
            k_reg   <= '0;
            r_reg   <= '0;
            c_reg   <= '0;
            bad_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            k_reg   <= k_next;
            r_reg   <= r_next;
            c_reg   <= c_next;
            bad_reg <= bad_next;
        end
    end

    assign ctrl.op = word.op;
    assign ctrl.go = go;
    assign k_idx   = k_reg;
    assign r_idx   = r_reg;
    assign c_idx   = c_reg;

endmodule

// File: rtl/dbc_datapath.sv
// ----------------------------------------------------------------------------
// dbc_datapath: distance memory, path adder and output register
// Two-port-read distance memory with registered reads, saturating path
// sum, relaxation compare and the result output stage.
// ----------------------------------------------------------------------------
module dbc_datapath #(
    parameter int NODES = 4,
    parameter int WEIGHT_BITS = 16,
    localparam int NODE_W = $clog2(NODES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dbc_pkg::ctrl_t                      ctrl,
    output dbc_pkg::status_t                    status,
    input  logic [NODE_W-1:0]                   k_idx,
    input  logic [NODE_W-1:0]                   r_idx,
    input  logic [NODE_W-1:0]                   c_idx,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [WEIGHT_BITS-1:0]       weight,
    input  logic                                weight_inf,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dbc_pkg::IDX_W-1:0]           out_row,
    output logic [dbc_pkg::IDX_W-1:0]           out_col,
    output logic signed [dbc_pkg::OUT_W-1:0]    out_dist,
    output logic                                out_dist_inf,
    output logic                                out_consistent,
    output logic                                out_last
);

    localparam int CELLS  = NODES * NODES;
    localparam int CELL_W = $clog2(CELLS);
    localparam int SW     = dbc_pkg::STORE_W;
    localparam int EXT_W  = (WEIGHT_BITS > SW) ? WEIGHT_BITS : SW;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    dbc_pkg::entry_t mem [CELLS];
    dbc_pkg::entry_t rd0_reg;
    dbc_pkg::entry_t rd1_reg;
    dbc_pkg::entry_t wr_data;
    dbc_pkg::entry_t load_entry;

    logic [CELL_W-1:0] addr_a;
    logic [CELL_W-1:0] addr_b;
    logic [CELL_W-1:0] addr_i;
    logic [CELL_W-1:0] rd0_addr;
    logic              wr_en;

    logic signed [SW-1:0]    val0;
    logic signed [SW-1:0]    val1;
    logic signed [SW:0]      sum_wide;
    logic signed [SW-1:0]    sum_reg;
    logic                    sum_inf_reg;
    logic signed [EXT_W-1:0] w_ext;
    logic signed [SW-1:0]    w_sat;
    logic                    improve;
    logic                    accept;
    logic                    load_out;

    logic                                out_valid_reg, out_valid_next;
    logic [dbc_pkg::IDX_W-1:0]           row_reg;
    logic [dbc_pkg::IDX_W-1:0]           col_reg;
    logic signed [dbc_pkg::OUT_W-1:0]    dist_reg;
    logic                                dinf_reg;
    logic                                cons_reg;
    logic                                last_reg;

    assign addr_a   = CELL_W'(r_idx * NODES + k_idx);
    assign addr_b   = CELL_W'(k_idx * NODES + c_idx);
    assign addr_i   = CELL_W'(r_idx * NODES + c_idx);
    assign rd0_addr = (ctrl.op == dbc_pkg::OP_RD_AB) ? addr_a : addr_i;

    assign in_ready = (ctrl.op == dbc_pkg::OP_LOAD);
    assign accept   = in_valid && in_ready;

    // Clamp the incoming weight into the store range
    assign w_ext = EXT_W'(weight);
    always_comb
    begin
        if ((&w_ext[EXT_W-1:SW-1]) || !(|w_ext[EXT_W-1:SW-1]))
            w_sat = w_ext[SW-1:0];
        else
            w_sat = w_ext[EXT_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end

    assign load_entry.inf = weight_inf;
    assign load_entry.val = weight_inf ? '0 : w_sat;

    assign val0     = rd0_reg.val;
    assign val1     = rd1_reg.val;
    assign sum_wide = (SW + 1)'(val0) + (SW + 1)'(val1);

    // Path through k improves the entry read last into port 0
    assign improve = !sum_inf_reg && (rd0_reg.inf || (val0 > sum_reg));

    assign wr_en = (ctrl.op == dbc_pkg::OP_LOAD && accept)
                || (ctrl.op == dbc_pkg::OP_RELAX && improve);

    always_comb
    begin
        if (ctrl.op == dbc_pkg::OP_LOAD)
            wr_data = load_entry;
        else
        begin
            wr_data.inf = 1'b0;
            wr_data.val = sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_i] <= wr_data;
        rd0_reg <= mem[rd0_addr];
        rd1_reg <= mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == dbc_pkg::OP_RD_I)
        begin
            sum_inf_reg <= rd0_reg.inf || rd1_reg.inf;
            sum_reg     <= dbc_pkg::sat_store(sum_wide);
        end
    end

    // Output stage
    assign load_out = ctrl.go
                   && (ctrl.op == dbc_pkg::OP_EMIT_LD || ctrl.op == dbc_pkg::OP_FAIL);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (ctrl.op == dbc_pkg::OP_FAIL)
            begin
                row_reg  <= '0;
                col_reg  <= '0;
                dist_reg <= '0;
                dinf_reg <= 1'b0;
                cons_reg <= 1'b0;
                last_reg <= 1'b1;
            end
            else
            begin
                row_reg  <= dbc_pkg::IDX_W'(r_idx);
                col_reg  <= dbc_pkg::IDX_W'(c_idx);
                dist_reg <= rd0_reg.inf ? '0 : dbc_pkg::sat_out(val0);
                dinf_reg <= rd0_reg.inf;
                cons_reg <= 1'b1;
                last_reg <= (r_idx == LAST_NODE) && (c_idx == LAST_NODE);
            end
        end
    end

    assign status.accept   = accept;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.improve  = improve;

    assign out_valid      = out_valid_reg;
    assign out_row        = row_reg;
    assign out_col        = col_reg;
    assign out_dist       = dist_reg;
    assign out_dist_inf   = dinf_reg;
    assign out_consistent = cons_reg;
    assign out_last       = last_reg;

endmodule

// File: rtl/difference_bound_closure.sv
// ----------------------------------------------------------------------------
// difference_bound_closure: all-pairs closure of a difference-bound matrix
// Loads NODES*NODES entries, relaxes them in place, sweeps once more for
// negative cycles and streams out the closed matrix or one failure item.
// ----------------------------------------------------------------------------
// Schedule: one input item a cycle while loading, when s_tvalid is high; after
// the last entry, the relax sweep, then the check sweep (which stops at the
// first improvement), then a read step and an emit step for each output item.
// Throughput: one matrix at a time, set by the three-step relax microcode
// loop on the single distance memory (two reads and one write a cycle).
// Reset: asynchronous; sequencer returns to loading, output goes empty.
module difference_bound_closure #(
    parameter int NODES = 4,
    parameter int WEIGHT_BITS = 16,
    localparam int S_DATA_W = ((WEIGHT_BITS + 7) / 8) * 8,
    localparam int NODE_W = $clog2(NODES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // entry_weight
    input  logic [0:0]          s_tuser,   // entry_infinite
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // row_index, col_index, distance
    output logic [1:0]          m_tuser,   // distance_infinite, consistent
    output logic                m_tlast
);

    dbc_pkg::ctrl_t   ctrl;
    dbc_pkg::status_t status;

    logic [NODE_W-1:0] k_idx;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] c_idx;

    logic [dbc_pkg::IDX_W-1:0]        row;
    logic [dbc_pkg::IDX_W-1:0]        col;
    logic signed [dbc_pkg::OUT_W-1:0] distance;
    logic                             dist_inf;
    logic                             consistent;

    dbc_sequencer #(
        .NODES (NODES)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .k_idx  (k_idx),
        .r_idx  (r_idx),
        .c_idx  (c_idx)
    );

    dbc_datapath #(
        .NODES       (NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .status         (status),
        .k_idx          (k_idx),
        .r_idx          (r_idx),
        .c_idx          (c_idx),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .weight         (s_tdata[WEIGHT_BITS-1:0]),
        .weight_inf     (s_tuser[0]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_row        (row),
        .out_col        (col),
        .out_dist       (distance),
        .out_dist_inf   (dist_inf),
        .out_consistent (consistent),
        .out_last       (m_tlast)
    );

    assign m_tdata = {2'b00, distance, col, row};
    assign m_tuser = {consistent, dist_inf};

`ifndef SYNTHESIS
    a_load_k_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (k_idx == '0))
        else $error("loading with nonzero intermediate-node counter");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && (ctrl.op == dbc_pkg::OP_EMIT_LD || ctrl.op == dbc_pkg::OP_FAIL))
        |-> (!m_tvalid || m_tready))
        else $error("output register loaded while an item is pending");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> m_tlast)
        else $error("inconsistent result not marked last");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of difference_bound_closure
// Loads 4x4 bound matrices entry by entry, predicts the closed matrix (or the
// single negative-cycle item) with a local Floyd-Warshall model, and checks
// every output item field by field, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_NODES     = 4;
    localparam int N_CELLS     = N_NODES * N_NODES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;

    localparam longint STORE_HI = (longint'(1) <<< (dbc_pkg::STORE_W - 1)) - 1;
    localparam longint STORE_LO = -(longint'(1) <<< (dbc_pkg::STORE_W - 1));
    localparam longint OUT_HI   = (longint'(1) <<< (dbc_pkg::OUT_W - 1)) - 1;
    localparam longint OUT_LO   = -(longint'(1) <<< (dbc_pkg::OUT_W - 1));

    typedef enum int {
        MAT_CONSISTENT,
        MAT_NOISE
    } matrix_kind_t;

    typedef struct {
        logic [1:0]                       row;
        logic [1:0]                       col;
        logic signed [dbc_pkg::OUT_W-1:0] distance;
        logic                             dist_inf;
        logic                             consistent;
        logic                             last;
    } cell_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // entry_weight
    logic [0:0]  s_tuser;    // entry_infinite
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // row_index, col_index, distance
    logic [1:0]  m_tuser;    // distance_infinite, consistent
    logic        m_tlast;

    // closure model state
    logic signed [dbc_pkg::STORE_W-1:0] bound_mem [N_CELLS];
    logic                               bound_inf [N_CELLS];
    int unsigned                        fill_count;

    cell_result_t closure_queue [$];
    cell_result_t want;
    int           mismatches = 0;
    int           cycles = 0;
    bit           idling_on;

    difference_bound_closure u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("difference_bound_closure verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Store one entry; on the last entry of a matrix, close it and queue results.
    task automatic absorb_entry(input logic signed [15:0] weight, input logic inf);
        longint       s;
        int           a, b, idx;
        bit           ok;
        cell_result_t res;
        if (fill_count >= N_CELLS)
            fill_count = 0;
        if (inf)
            bound_mem[fill_count] = '0;
        else
            bound_mem[fill_count] = {{(dbc_pkg::STORE_W - 16){weight[15]}}, weight};
        bound_inf[fill_count] = inf;
        fill_count++;
        if (fill_count < N_CELLS)
            return;
        fill_count = 0;

        for (int mid = 0; mid < N_NODES; mid++)
            for (int row = 0; row < N_NODES; row++)
                for (int col = 0; col < N_NODES; col++)
                begin
                    a   = row * N_NODES + mid;
                    b   = mid * N_NODES + col;
                    idx = row * N_NODES + col;
                    if (!bound_inf[a] && !bound_inf[b])
                    begin
                        s = longint'(bound_mem[a]) + longint'(bound_mem[b]);
                        if (s > STORE_HI) s = STORE_HI;
                        if (s < STORE_LO) s = STORE_LO;
                        if (bound_inf[idx] || longint'(bound_mem[idx]) > s)
                        begin
                            bound_mem[idx] = s[dbc_pkg::STORE_W-1:0];
                            bound_inf[idx] = 1'b0;
                        end
                    end
                end

        // any further improvement means a negative cycle
        ok = 1'b1;
        for (int mid = 0; mid < N_NODES; mid++)
            for (int row = 0; row < N_NODES; row++)
                for (int col = 0; col < N_NODES; col++)
                begin
                    a   = row * N_NODES + mid;
                    b   = mid * N_NODES + col;
                    idx = row * N_NODES + col;
                    if (!bound_inf[a] && !bound_inf[b])
                    begin
                        s = longint'(bound_mem[a]) + longint'(bound_mem[b]);
                        if (s > STORE_HI) s = STORE_HI;
                        if (s < STORE_LO) s = STORE_LO;
                        if (bound_inf[idx] || longint'(bound_mem[idx]) > s)
                            ok = 1'b0;
                    end
                end

        if (!ok)
        begin
            res = '{row: 2'd0, col: 2'd0, distance: '0, dist_inf: 1'b0,
                    consistent: 1'b0, last: 1'b1};
            closure_queue = {closure_queue, res};
            return;
        end
        for (int i = 0; i < N_CELLS; i++)
        begin
            s = longint'(bound_mem[i]);
            if (s > OUT_HI) s = OUT_HI;
            if (s < OUT_LO) s = OUT_LO;
            res.row        = 2'(i / N_NODES);
            res.col        = 2'(i % N_NODES);
            res.distance   = bound_inf[i] ? '0 : s[dbc_pkg::OUT_W-1:0];
            res.dist_inf   = bound_inf[i];
            res.consistent = 1'b1;
            res.last       = (i == N_CELLS - 1);
            closure_queue = {closure_queue, res};
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_entry(input logic [15:0] weight, input logic inf);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= weight;
        s_tuser[0] <= inf;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_entry(weight, inf);
        @(negedge clk);
    endtask

    task automatic send_matrix(input matrix_kind_t kind);
        int          pot [N_NODES];
        logic [15:0] weight;
        logic        inf;
        for (int i = 0; i < N_NODES; i++)
            pot[i] = int'($urandom_range(0, 16383)) - 8192;
        for (int row = 0; row < N_NODES; row++)
            for (int col = 0; col < N_NODES; col++)
            begin
                weight = 16'($urandom);
                if (kind == MAT_NOISE)
                    inf = ($urandom_range(0, 4) == 0);
                else
                begin
                    // potential-based bounds cannot form a negative cycle
                    inf = (row != col) && ($urandom_range(0, 5) == 0);
                    if (!inf)
                    begin
                        if (row == col)
                            weight = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 999))
                                                                 : 16'd0;
                        else
                            weight = 16'(pot[col] - pot[row] +
                                         int'($urandom_range(0, 16383)));
                    end
                end
                send_entry(weight, inf);
            end
    endtask

    // Chain with a back edge and full-scale weights; ignored bits on infinite entries.
    task automatic test_chain_extremes();
        send_entry(16'd0, 1'b0);      send_entry(16'h8000, 1'b0);
        send_entry(16'hFFFF, 1'b1);   send_entry(16'h8000, 1'b1);
        send_entry(16'h7FFF, 1'b1);   send_entry(16'd0, 1'b0);
        send_entry(16'h7FFF, 1'b0);   send_entry(16'h0000, 1'b1);
        send_entry(16'h5555, 1'b1);   send_entry(16'hAAAA, 1'b1);
        send_entry(16'd0, 1'b0);      send_entry(16'h8000, 1'b0);
        send_entry(16'h0001, 1'b1);   send_entry(16'h7FFF, 1'b0);
        send_entry(16'hFFFE, 1'b1);   send_entry(16'd5, 1'b0);
    endtask

    // Two-node cycle of total weight -1 must yield the single failure item.
    task automatic test_negative_cycle();
        for (int row = 0; row < N_NODES; row++)
            for (int col = 0; col < N_NODES; col++)
            begin
                if (row == col)
                    send_entry(16'd0, 1'b0);
                else if (row == 0 && col == 1)
                    send_entry(-16'sd5, 1'b0);
                else if (row == 1 && col == 0)
                    send_entry(16'd4, 1'b0);
                else if (row == 3)
                    send_entry(16'hFFFF, 1'b1);
                else
                    send_entry(16'd100, 1'b0);
            end
    endtask

    task automatic test_random_consistent();
        repeat (12) send_matrix(MAT_CONSISTENT);
    endtask

    task automatic test_random_noise();
        repeat (4) send_matrix(MAT_NOISE);
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        repeat (3) send_matrix(MAT_CONSISTENT);
        send_matrix(MAT_NOISE);
    endtask

    // sink: random stall bursts while idling is on
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (closure_queue.size() == 0)
                report_mismatch("output item with nothing expected");
            else
            begin
                want = closure_queue.pop_front();
                if (m_tdata[1:0] !== want.row)
                    report_mismatch($sformatf("row_index %0d, expected %0d",
                                              m_tdata[1:0], want.row));
                if (m_tdata[3:2] !== want.col)
                    report_mismatch($sformatf("col_index %0d, expected %0d",
                                              m_tdata[3:2], want.col));
                if (m_tdata[21:4] !== want.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d (cell %0d,%0d)",
                                              $signed(m_tdata[21:4]), want.distance,
                                              want.row, want.col));
                if (m_tuser[0] !== want.dist_inf)
                    report_mismatch($sformatf("distance_infinite %b, expected %b",
                                              m_tuser[0], want.dist_inf));
                if (m_tuser[1] !== want.consistent)
                    report_mismatch($sformatf("consistent %b, expected %b",
                                              m_tuser[1], want.consistent));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        fill_count = 0;
        idling_on  = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_chain_extremes();
        test_negative_cycle();
        test_random_consistent();
        test_random_noise();
        test_back_to_back();
        s_tvalid <= 1'b0;

        while (closure_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && closure_queue.size() == 0)
            $display("difference_bound_closure verification clean");
        else
            $display("difference_bound_closure verification failed");
        $finish;
    end

endmodule

// File: difference_bound_closure.f
rtl/dbc_pkg.sv
rtl/dbc_sequencer.sv
rtl/dbc_datapath.sv
rtl/difference_bound_closure.sv
sim/tb_top.sv
